[hdl/sac_pkg.sv]
`timescale 1ns / 1ps
package sac_pkg;

    localparam int DEFAULT_MAX_CLASSES = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    localparam int CPP_W = 9;
    localparam logic [CPP_W-1:0] CPP_RESET = 9'd1;
    localparam logic [31:0] NO_LABEL_COLOR = 32'h0000_00FF;
    localparam logic REG_CPP = 1'b0;

    typedef enum logic {
        KIND_SCORE = 1'b0,
        KIND_PALETTE = 1'b1
    } t_kind;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        t_op op;
        logic [7:0] idx;
        logic check;
        logic [31:0] color;
        logic mark;
    } t_cmd;

endpackage

[hdl/sac_front.sv]
`timescale 1ns / 1ps
module sac_front #(
    parameter int MAX_CLASSES = sac_pkg::DEFAULT_MAX_CLASSES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sac_pkg::CPP_W-1:0] i_cfg_data,
    output logic [sac_pkg::CPP_W-1:0] o_cfg_value,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic signed [31:0]        i_score,
    input  logic                      i_score_last,
    input  logic [7:0]                i_palette_index,
    input  logic [31:0]               i_palette_color,
    input  logic                      i_palette_valid,
    input  logic                      i_full,
    output logic                      o_push,
    output sac_pkg::t_cmd             o_cmd
);
    localparam int CLASS_LIMIT = (MAX_CLASSES > 256) ? 255 : MAX_CLASSES - 1;
    localparam int COUNT_LIMIT = (MAX_CLASSES > 511) ? 511 : MAX_CLASSES;

    logic [sac_pkg::CPP_W-1:0] r_cpp;
    logic signed [31:0]        r_best_score;
    logic [7:0]                r_best_class;
    logic [8:0]                r_count;

    logic               accept;
    logic               is_score;
    logic [8:0]         n_eff;
    logic               take;
    logic signed [31:0] new_score;
    logic [7:0]         new_class;
    logic [8:0]         cnt_inc;
    logic               pixel_end;
    logic               idx_ok;
    logic [7:0]         lk_id;
    logic               lk_check;

    assign accept   = i_valid && !i_full;
    assign is_score = (i_kind == sac_pkg::KIND_SCORE);
    assign o_stall  = i_full;
    assign o_cfg_value = r_cpp;

    always_comb begin
        if (r_cpp == '0) begin
            n_eff = 9'd1;
        end else if (r_cpp > 9'(COUNT_LIMIT)) begin
            n_eff = 9'(COUNT_LIMIT);
        end else begin
            n_eff = r_cpp;
        end
    end

    always_comb begin
        take = (r_count == '0) || (i_score > r_best_score);
        if (take) begin
            new_score = i_score;
            new_class = (r_count > 9'(CLASS_LIMIT)) ? 8'(CLASS_LIMIT) : r_count[7:0];
        end else begin
            new_score = r_best_score;
            new_class = r_best_class;
        end
        cnt_inc   = r_count + 9'd1;
        pixel_end = i_score_last || (cnt_inc >= n_eff);
        idx_ok    = 11'(i_palette_index) < 11'(MAX_CLASSES);
    end

    always_comb begin
        if (n_eff == 9'd1) begin
            if (new_score[31]) begin
                lk_id    = 8'd0;
                lk_check = 1'b0;
            end else if (new_score[31:16] > 16'(CLASS_LIMIT)) begin
                lk_id    = 8'(CLASS_LIMIT);
                lk_check = 1'b0;
            end else begin
                lk_id    = new_score[23:16];
                lk_check = 1'b1;
            end
        end else begin
            lk_id    = new_class;
            lk_check = 1'b1;
        end
    end

    always_comb begin
        o_cmd.op    = is_score ? sac_pkg::OP_LOOKUP : sac_pkg::OP_WRITE;
        o_cmd.idx   = is_score ? lk_id : i_palette_index;
        o_cmd.check = lk_check;
        o_cmd.color = i_palette_color;
        o_cmd.mark  = i_palette_valid;
        o_push      = accept && (is_score ? pixel_end : idx_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpp <= sac_pkg::CPP_RESET;
        end else if (i_cfg_we) begin
            r_cpp <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_class <= '0;
            r_count      <= '0;
        end else if (accept && is_score) begin
            if (pixel_end) begin
                r_best_score <= '0;
                r_best_class <= '0;
                r_count      <= '0;
            end else begin
                r_best_score <= new_score;
                r_best_class <= new_class;
                r_count      <= cnt_inc;
            end
        end
    end

endmodule

[hdl/sac_queue.sv]
`timescale 1ns / 1ps
module sac_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sac_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output sac_pkg::t_cmd o_cmd,
    output logic          o_avail
);
    sac_pkg::t_cmd r_buf [sac_pkg::QUEUE_DEPTH];
    logic [sac_pkg::QUEUE_AW-1:0] r_wr;
    logic [sac_pkg::QUEUE_AW-1:0] r_rd;
    logic [sac_pkg::QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (sac_pkg::QUEUE_AW + 1)'(sac_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hdl/sac_back.sv]
`timescale 1ns / 1ps
module sac_back #(
    parameter int MAX_CLASSES = sac_pkg::DEFAULT_MAX_CLASSES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sac_pkg::t_cmd i_cmd,
    input  logic          i_avail,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic [7:0]    o_alpha,
    output logic [7:0]    o_class_id,
    output logic          o_label_found
);
    localparam int PAL_DEPTH = (MAX_CLASSES > 256) ? 256 : MAX_CLASSES;
    localparam int PAL_AW = $clog2(PAL_DEPTH);

    logic [31:0]          r_mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] r_marks;

    logic        r_s1_valid;
    logic [31:0] r_s1_color;
    logic [7:0]  r_s1_id;
    logic        r_s1_found;

    logic        r_out_valid;
    logic [31:0] r_out_color;
    logic [7:0]  r_out_id;
    logic        r_out_found;

    logic              s2_ready;
    logic              s1_ready;
    logic              is_write;
    logic              pop_wr;
    logic              pop_lk;
    logic [PAL_AW-1:0] addr;

    assign s2_ready = !r_out_valid || !i_stall;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign is_write = (i_cmd.op == sac_pkg::OP_WRITE);
    assign o_pop    = i_avail && (is_write || s1_ready);
    assign pop_wr   = o_pop && is_write;
    assign pop_lk   = o_pop && !is_write;
    assign addr     = i_cmd.idx[PAL_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (pop_wr) begin
            r_mem[addr] <= i_cmd.color;
        end
        if (pop_lk) begin
            r_s1_color <= r_mem[addr];
            r_s1_id    <= i_cmd.idx;
            r_s1_found <= i_cmd.check && r_marks[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (pop_wr) begin
            r_marks[addr] <= i_cmd.mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_lk) begin
                r_s1_valid <= 1'b1;
            end else if (s2_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_out_color <= r_s1_found ? r_s1_color : sac_pkg::NO_LABEL_COLOR;
            r_out_id    <= r_s1_id;
            r_out_found <= r_s1_found;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_red         = r_out_color[31:24];
    assign o_green       = r_out_color[23:16];
    assign o_blue        = r_out_color[15:8];
    assign o_alpha       = r_out_color[7:0];
    assign o_class_id    = r_out_id;
    assign o_label_found = r_out_found;

endmodule

[hdl/segmentation_argmax_colorizer_unit.sv]
`timescale 1ns / 1ps
// Path: a pixel command goes via the queue, the palette read stage and the output register.
// Throughput: one word per cycle in and one pixel result per cycle out, each unless stalled;
// set by the single running compare in the front and the one-port palette read in the back.
// Reset: synchronous, active low; clears the running argmax, the queue, the pipeline valids,
// the palette label marks, and sets classes_per_pixel to 1. Palette colors are not cleared.
module segmentation_argmax_colorizer_unit #(
    parameter int MAX_CLASSES = sac_pkg::DEFAULT_MAX_CLASSES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic signed [31:0] i_score,
    input  logic               i_score_last,
    input  logic [7:0]         i_palette_index,
    input  logic [31:0]        i_palette_color,
    input  logic               i_palette_valid,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic [7:0]         o_class_id,
    output logic               o_label_found
);
    logic                      cfg_we;
    logic [sac_pkg::CPP_W-1:0] cfg_value;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_avail;
    sac_pkg::t_cmd             q_in;
    sac_pkg::t_cmd             q_out;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == sac_pkg::REG_CPP);
    assign prdata = (paddr[2] == sac_pkg::REG_CPP) ?
                    {{(32 - sac_pkg::CPP_W){1'b0}}, cfg_value} : 32'd0;

    sac_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[sac_pkg::CPP_W-1:0]),
        .o_cfg_value     (cfg_value),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_kind          (i_kind),
        .i_score         (i_score),
        .i_score_last    (i_score_last),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_palette_valid (i_palette_valid),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_cmd           (q_in)
    );

    sac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_avail (q_avail)
    );

    sac_back #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_out),
        .i_avail       (q_avail),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_class_id    (o_class_id),
        .o_label_found (o_label_found)
    );

endmodule

[hdl/sac_checker.sv]
`timescale 1ns / 1ps
module sac_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_kind,
    input logic signed [31:0] i_score,
    input logic               i_score_last,
    input logic [7:0]         i_palette_index,
    input logic [31:0]        i_palette_color,
    input logic               i_palette_valid,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [7:0]         o_red,
    input logic [7:0]         o_green,
    input logic [7:0]         o_blue,
    input logic [7:0]         o_alpha,
    input logic [7:0]         o_class_id,
    input logic               o_label_found
);

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    a_no_label_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_label_found) |->
            (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'hFF))
        else $error("unlabeled class not opaque black");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_alpha)
             && $stable(o_class_id) && $stable(o_label_found)))
        else $error("result word changed while stalled");

endmodule

bind segmentation_argmax_colorizer_unit sac_checker u_sac_checker (.*);

[dv/segmentation_argmax_colorizer_unit_test.sv]
`timescale 1ns / 1ps
package colorizer_tb_pkg;
    import sac_pkg::*;

    localparam int COUNT_LIMIT = DEFAULT_MAX_CLASSES > 511 ? 511 : DEFAULT_MAX_CLASSES;
    localparam int CLASS_LIMIT = DEFAULT_MAX_CLASSES > 256 ? 255 : DEFAULT_MAX_CLASSES - 1;

    typedef struct {
        t_kind              kind;
        logic signed [31:0] score;
        logic               is_last;
        logic [7:0]         pal_index;
        logic [31:0]        pal_color;
        logic               pal_valid;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] class_id;
        logic       label_found;
    } pixel_t;

    class pixel_color_scoreboard;
        logic [31:0]        pal_color [256];
        logic               pal_mark [256];
        logic signed [31:0] best_score;
        logic [7:0]         best_class;
        logic [8:0]         class_count;
        logic [8:0]         classes_per_pixel;
        pixel_t             expected_pixels [$];
        int                 mismatch_count;

        function new();
            for (int i = 0; i < 256; i++) begin
                pal_color[i] = '0;
                pal_mark[i] = 1'b0;
            end
            best_score = '0;
            best_class = '0;
            class_count = '0;
            classes_per_pixel = CPP_RESET;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_word(in_word_t w);
            int          n;
            logic [15:0] ipart;
            logic [7:0]  id;
            logic        found;
            logic [31:0] color;
            if (w.kind == KIND_PALETTE) begin
                pal_color[w.pal_index] = w.pal_color;
                pal_mark[w.pal_index] = w.pal_valid;
                return;
            end
            n = classes_per_pixel == 0 ? 1 :
                classes_per_pixel > COUNT_LIMIT ? COUNT_LIMIT : int'(classes_per_pixel);
            if (class_count == 0 || w.score > best_score) begin
                best_score = w.score;
                best_class = class_count > CLASS_LIMIT ? 8'(CLASS_LIMIT) : class_count[7:0];
            end
            class_count = class_count + 9'd1;
            if (!w.is_last && class_count < n) return;
            if (n == 1) begin
                ipart = best_score[31:16];
                if (best_score[31]) begin
                    id = 8'd0;
                    found = 1'b0;
                end else if (ipart > CLASS_LIMIT) begin
                    id = 8'(CLASS_LIMIT);
                    found = 1'b0;
                end else begin
                    id = ipart[7:0];
                    found = pal_mark[id];
                end
            end else begin
                id = best_class;
                found = pal_mark[id];
            end
            color = found ? pal_color[id] : NO_LABEL_COLOR;
            expected_pixels.push_back('{color[31:24], color[23:16], color[15:8], color[7:0],
                                        id, found});
            best_score = '0;
            best_class = '0;
            class_count = '0;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                $error("pixel word with no expectation: class_id %0h", got.class_id);
                mismatch_count++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("alpha", want.alpha, got.alpha);
            check_field("class_id", want.class_id, got.class_id);
            check_field("label_found", 8'(want.label_found), 8'(got.label_found));
        endfunction
    endclass
endpackage

module segmentation_argmax_colorizer_unit_test;
    import sac_pkg::*;
    import colorizer_tb_pkg::*;

    localparam int LATENCY = 3;
    localparam int CYCLE_LIMIT = 250000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic signed [31:0] i_score;
    logic               i_score_last;
    logic [7:0]         i_palette_index;
    logic [31:0]        i_palette_color;
    logic               i_palette_valid;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_alpha;
    logic [7:0]         o_class_id;
    logic               o_label_found;

    pixel_color_scoreboard board;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    segmentation_argmax_colorizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_score         (i_score),
        .i_score_last    (i_score_last),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_palette_valid (i_palette_valid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_class_id      (o_class_id),
        .o_label_found   (o_label_found)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("segmentation_argmax_colorizer_unit_test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= $urandom_range(99) < stall_pct;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            board.check_pixel('{o_red, o_green, o_blue, o_alpha, o_class_id, o_label_found});
        end
    end

    function automatic in_word_t score_word(logic signed [31:0] score, logic is_last);
        return '{KIND_SCORE, score, is_last, 8'($urandom), 32'($urandom), 1'($urandom)};
    endfunction

    function automatic in_word_t palette_word(logic [7:0] idx, logic [31:0] color,
                                              logic valid);
        return '{KIND_PALETTE, 32'($urandom), 1'($urandom), idx, color, valid};
    endfunction

    function automatic logic signed [31:0] rand_score(int n);
        int pick;
        int tie;
        pick = $urandom_range(99);
        tie = $urandom_range(4);
        if (n == 1) begin
            if (pick < 70) return {16'($urandom_range(263)), 16'($urandom)};
            if (pick < 80) return {1'b1, 31'($urandom)};
            return 32'($urandom);
        end
        if (pick < 50) return 32'($urandom);
        if (pick < 80) return {16'(tie - 2), 16'h0000};
        return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= w.kind;
        i_score <= w.score;
        i_score_last <= w.is_last;
        i_palette_index <= w.pal_index;
        i_palette_color <= w.pal_color;
        i_palette_valid <= w.pal_valid;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.note_word(w);
    endtask

    // hold off until every pixel word is back, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [8:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_CPP);
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.classes_per_pixel = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_phase(input logic [8:0] cpp, input int count, input int mode);
        int n;
        int len;
        int sent;
        send_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 27 : 0;
        stall_pct = (mode == 2) ? 79 : (mode == 3) ? 27 : 0;
        write_reg(cpp);
        n = cpp == 0 ? 1 : cpp > COUNT_LIMIT ? COUNT_LIMIT : int'(cpp);
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(n < 12 ? n : 12, 1);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 15) begin
                    send_word(palette_word($urandom_range(99) < 70 ? 8'($urandom_range(15))
                                                                   : 8'($urandom),
                                           32'($urandom), $urandom_range(99) < 75));
                end
                send_word(score_word(rand_score(n),
                                     k != len - 1 ? 1'b0 :
                                     len == n ? 1'($urandom_range(1)) : 1'b1));
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_kind = KIND_SCORE;
        i_score = '0;
        i_score_last = 1'b0;
        i_palette_index = '0;
        i_palette_color = '0;
        i_palette_valid = 1'b0;
        i_out_stall = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // class-ID mode straight out of reset
        send_word(palette_word(8'd0, 32'h1122_3344, 1'b1));
        send_word(palette_word(8'd255, 32'hFFFF_FFFF, 1'b1));
        send_word(palette_word(8'd7, 32'hA5A5_A5A5, 1'b0));
        send_word(palette_word(8'd3, 32'h0000_0000, 1'b1));
        send_word(score_word(32'sh0000_0000, 1'b1));
        send_word(score_word(32'sh00FF_FFFF, 1'b0));
        send_word(score_word(32'sh0007_0000, 1'b1));
        send_word(score_word(32'sh0003_8000, 1'b0));
        send_word(score_word(32'sh8000_0000, 1'b1));
        send_word(score_word(32'shFFFF_FFFF, 1'b0));
        send_word(score_word(32'sh7FFF_FFFF, 1'b1));
        send_word(score_word(32'sh0100_0000, 1'b0));
        send_word(score_word(32'sh0005_0000, 1'b1));
        drain();

        // argmax over three classes: ties, extremes, early end
        write_reg(9'd3);
        send_word(score_word(32'sh0005_0000, 1'b0));
        send_word(score_word(32'sh0005_0000, 1'b0));
        send_word(score_word(32'sh0005_0000, 1'b0));
        send_word(score_word(32'sh0001_0000, 1'b0));
        send_word(palette_word(8'd1, 32'hDEAD_BEEF, 1'b1));
        send_word(score_word(32'sh0009_0000, 1'b0));
        send_word(score_word(32'sh0009_0000, 1'b1));
        send_word(score_word(32'sh8000_0000, 1'b0));
        send_word(score_word(32'sh7FFF_FFFF, 1'b0));
        send_word(score_word(32'sh0000_0000, 1'b0));
        send_word(score_word(32'shFFFF_FFFF, 1'b0));
        send_word(score_word(32'shFFFF_FFFE, 1'b1));
        drain();

        random_phase(9'd1, 18, 0);
        random_phase(9'd2, 18, 1);
        random_phase(9'd0, 18, 2);
        random_phase(9'd5, 18, 3);
        random_phase(9'd256, 18, 0);
        random_phase(9'd511, 18, 1);
        random_phase(9'd16, 18, 2);
        random_phase(9'd7, 18, 3);

        // full pixel ended by the class count alone, winner in the top class
        write_reg(9'd511);
        send_word(palette_word(8'd255, 32'h0102_0304, 1'b1));
        for (int k = 0; k < COUNT_LIMIT; k++) begin
            send_word(score_word(32'(k - 128) <<< 16, 1'b0));
        end
        drain();

        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("segmentation_argmax_colorizer_unit_test passed");
        end else begin
            $display("segmentation_argmax_colorizer_unit_test failed");
        end
        $finish;
    end
endmodule
